### design/madt_pkg.sv
// Shared types and constants for the MADT table stream parser.
package madt_pkg;

	localparam logic KIND_CPU = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	localparam logic [7:0] REC_LAPIC  = 8'd0;
	localparam logic [7:0] REC_IOAPIC = 8'd1;

	localparam logic [31:0] HDR_SUM_FIXED = 32'd8;
	localparam logic [29:0] HDR_LEN_WORD  = 30'd1;
	localparam logic [29:0] HDR_LAPIC_WORD = 30'd9;
	localparam logic [31:0] WALK_START    = 32'd44;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [3:0]  cpu_slot;
		logic [7:0]  apic_ident;
		logic        cpu_on;
		logic        sum_ok;
		logic [31:0] local_apic_base;
		logic [31:0] io_apic_base;
		logic [7:0]  io_apic_ident;
		logic [31:0] irq_base;
		logic [4:0]  cpus_seen;
		logic        walk_halted;
	} res_t;

endpackage

### design/madt_table_stream_parser_top.sv
// Top level of the MADT table stream parser: stream ports and result register.
//
//  channel  dir  beat content                         tlast        tuser
//  s_*      in   one table byte (tdata[7:0])          final byte   -
//  m_*      out  CPU record or end-of-table summary   -            result kind
//
//  Each byte beat is absorbed directly: header capture, checksum and
//  record walk are a single combinational step into the walk registers.
//  Results land in one output register; s_tready = !m_tvalid || m_tready,
//  so a new byte is taken in the same cycle a waiting result is taken.
//  Sustained rate is one byte per cycle while the sink keeps up.
//  arst_n clears the walk state and the output valid; after a summary the
//  walk state returns to its reset values for the next table.
module madt_table_stream_parser_top #(
	parameter int CPU_LIMIT = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,    // [7:0] table_byte
	input  logic         s_tlast,    // final_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,    // cpu_slot[3:0], apic_ident[11:4], cpu_on[12],
	                                 // sum_ok[13], local_apic_base[45:14],
	                                 // io_apic_base[77:46], io_apic_ident[85:78],
	                                 // irq_base[117:86], cpus_seen[122:118],
	                                 // walk_halted[123], zero pad [127:124]
	output logic         m_tuser     // result_kind: 0 CPU, 1 summary
);

	logic           beat;
	madt_pkg::res_t res;
	logic [127:0]   data_q;
	logic           kind_q;
	logic           valid_q;

	assign s_tready = !valid_q || m_tready;
	assign beat     = s_tvalid && s_tready;

	madt_walk #(
		.CPU_LIMIT(CPU_LIMIT)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat    (beat),
		.byte_in (s_tdata),
		.last    (s_tlast),
		.res     (res)
	);

	// output valid: set by a beat with a result, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (beat) begin
			valid_q <= res.valid;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload: loaded only when a result is produced
	always_ff @(posedge clk) begin
		if (beat && res.valid) begin
			kind_q <= res.kind;
			data_q <= {4'd0, res.walk_halted, res.cpus_seen, res.irq_base,
				res.io_apic_ident, res.io_apic_base, res.local_apic_base,
				res.sum_ok, res.cpu_on, res.apic_ident, res.cpu_slot};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule

### design/madt_walk.sv
// Per-byte header capture, checksum and record walk of the MADT parser.
module madt_walk #(
	parameter int CPU_LIMIT = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat,
	input  logic [7:0]       byte_in,
	input  logic             last,
	output madt_pkg::res_t   res
);

	localparam int CW = $clog2(CPU_LIMIT + 1);
	localparam logic [CW-1:0] LIMIT_C = CW'(CPU_LIMIT);

	logic [31:0]   off_q, dlen_q, rstart_q, lapic_q, ioabase_q, irq_q;
	logic [7:0]    sum_q, rtype_q, rlen_q, rid_q, ioid_q;
	logic [63:0]   scratch_q;
	logic [CW-1:0] cnt_q;
	logic          halt_q;

	logic [31:0]   off_nx, dlen_nx, rstart_nx, lapic_nx, ioabase_nx, irq_nx;
	logic [7:0]    sum_nx, rtype_nx, rlen_nx, rid_nx, ioid_nx;
	logic [63:0]   scratch_nx;
	logic [CW-1:0] cnt_nx;
	logic          halt_nx;

	logic          active, fits, at_type, at_len, in_body, bad_len, finish;
	logic          cpu_hit;
	logic [31:0]   diff;
	logic [7:0]    pos;
	logic [CW+4:0] cnt_ext, slot_ext;
	logic [CW-1:0] slot;

	always_comb begin
		sum_nx     = sum_q;
		dlen_nx    = dlen_q;
		lapic_nx   = lapic_q;
		rstart_nx  = rstart_q;
		rtype_nx   = rtype_q;
		rlen_nx    = rlen_q;
		scratch_nx = scratch_q;
		rid_nx     = rid_q;
		ioabase_nx = ioabase_q;
		ioid_nx    = ioid_q;
		irq_nx     = irq_q;
		cnt_nx     = cnt_q;
		halt_nx    = halt_q;
		finish     = 1'b0;
		cpu_hit    = 1'b0;
		slot       = cnt_q;

		if (off_q < madt_pkg::HDR_SUM_FIXED || off_q < dlen_q) begin
			sum_nx = sum_q + byte_in;
		end
		if (off_q[31:2] == madt_pkg::HDR_LEN_WORD) begin
			dlen_nx[off_q[1:0]*8 +: 8] = byte_in;
		end
		if (off_q[31:2] == madt_pkg::HDR_LAPIC_WORD) begin
			lapic_nx[off_q[1:0]*8 +: 8] = byte_in;
		end

		active  = !halt_q && off_q >= madt_pkg::WALK_START;
		fits    = ({1'b0, rstart_q} + 33'd2) <= {1'b0, dlen_q};
		at_type = off_q == rstart_q;
		at_len  = {1'b0, off_q} == ({1'b0, rstart_q} + 33'd1);
		diff    = off_q - rstart_q;
		in_body = ({1'b0, off_q} > ({1'b0, rstart_q} + 33'd1)) && (diff < {24'd0, rlen_q});
		pos     = diff[7:0];
		bad_len = byte_in < 8'd2 || ({1'b0, rstart_q} + {25'd0, byte_in}) > {1'b0, dlen_q};

		if (active && fits) begin
			if (at_type) begin
				rtype_nx   = byte_in;
				scratch_nx = '0;
				rid_nx     = '0;
			end else if (at_len) begin
				rlen_nx = byte_in;
				if (bad_len) begin
					halt_nx = 1'b1;
				end else if (byte_in == 8'd2) begin
					finish = 1'b1;
				end
			end else if (in_body) begin
				if (pos == 8'd2 && rtype_q == madt_pkg::REC_IOAPIC) begin
					rid_nx = byte_in;
				end
				if (pos == 8'd3 && rtype_q == madt_pkg::REC_LAPIC) begin
					rid_nx = byte_in;
				end
				for (int k = 0; k < 8; k++) begin
					if (pos == 8'(k + 4)) begin
						scratch_nx[k*8 +: 8] = byte_in;
					end
				end
				if (pos + 8'd1 == rlen_q) begin
					finish = 1'b1;
				end
			end
		end

		if (finish) begin
			// record closed: use the body as captured including this byte
			if (rtype_nx == madt_pkg::REC_LAPIC) begin
				if (cnt_q < LIMIT_C) begin
					cpu_hit = 1'b1;
					cnt_nx  = cnt_q + 1'b1;
				end
			end else if (rtype_nx == madt_pkg::REC_IOAPIC) begin
				if (ioabase_q == 32'd0) begin
					ioabase_nx = scratch_nx[31:0];
					ioid_nx    = rid_nx;
					irq_nx     = scratch_nx[63:32];
				end
			end
			rstart_nx = rstart_q + {24'd0, rlen_nx};
		end

		off_nx = (off_q == 32'hFFFF_FFFF) ? off_q : off_q + 32'd1;

		cnt_ext  = {5'd0, cnt_nx};
		slot_ext = {5'd0, slot};

		res = '0;
		if (last) begin
			res.valid           = 1'b1;
			res.kind            = madt_pkg::KIND_SUM;
			res.sum_ok          = sum_nx == 8'd0;
			res.local_apic_base = lapic_nx;
			res.io_apic_base    = ioabase_nx;
			res.io_apic_ident   = ioid_nx;
			res.irq_base        = irq_nx;
			res.cpus_seen       = cnt_ext[4:0];
			res.walk_halted     = halt_nx;
		end else if (cpu_hit) begin
			res.valid      = 1'b1;
			res.kind       = madt_pkg::KIND_CPU;
			res.cpu_slot   = slot_ext[3:0];
			res.apic_ident = rid_nx;
			res.cpu_on     = scratch_nx[0];
		end

		// summary beat: walk state returns to reset for the next table
		if (last) begin
			off_nx     = '0;
			dlen_nx    = '0;
			sum_nx     = '0;
			rstart_nx  = madt_pkg::WALK_START;
			rtype_nx   = '0;
			rlen_nx    = '0;
			scratch_nx = '0;
			rid_nx     = '0;
			lapic_nx   = '0;
			ioabase_nx = '0;
			ioid_nx    = '0;
			irq_nx     = '0;
			cnt_nx     = '0;
			halt_nx    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			dlen_q    <= '0;
			sum_q     <= '0;
			rstart_q  <= madt_pkg::WALK_START;
			rtype_q   <= '0;
			rlen_q    <= '0;
			scratch_q <= '0;
			rid_q     <= '0;
			lapic_q   <= '0;
			ioabase_q <= '0;
			ioid_q    <= '0;
			irq_q     <= '0;
			cnt_q     <= '0;
			halt_q    <= 1'b0;
		end else if (beat) begin
			off_q     <= off_nx;
			dlen_q    <= dlen_nx;
			sum_q     <= sum_nx;
			rstart_q  <= rstart_nx;
			rtype_q   <= rtype_nx;
			rlen_q    <= rlen_nx;
			scratch_q <= scratch_nx;
			rid_q     <= rid_nx;
			lapic_q   <= lapic_nx;
			ioabase_q <= ioabase_nx;
			ioid_q    <= ioid_nx;
			irq_q     <= irq_nx;
			cnt_q     <= cnt_nx;
			halt_q    <= halt_nx;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LIMIT_C)
		else $error("cpu count above limit");

	a_table_restart: assert property (@(posedge clk) disable iff (!arst_n)
		beat && last |=> off_q == 32'd0 && cnt_q == '0 && !halt_q)
		else $error("state not cleared after summary");

	a_cpu_counted: assert property (@(posedge clk) disable iff (!arst_n)
		beat && res.valid && res.kind == madt_pkg::KIND_CPU |=>
		cnt_q == $past(cnt_q) + 1'b1)
		else $error("cpu result without count step");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q && !(beat && last) |=> halt_q)
		else $error("halt dropped inside a table");
`endif

endmodule

### sim/tb_madt_table_stream_parser_top.sv
// Self-checking testbench for the MADT table stream parser.
`timescale 1ns / 100ps

module tb_madt_table_stream_parser_top;

	localparam int          CPU_CAP      = 16;
	localparam int unsigned TARGET_BYTES = 1800;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// record types the stimulus builds besides the two the parser acts on
	localparam logic [7:0] REC_OVERRIDE = 8'd2;
	localparam logic [7:0] REC_NMI      = 8'd4;

	// shape of a generated table; plain tables fill the rest of each round of ten
	typedef enum int {
		SHAPE_NOISE,
		SHAPE_CPU_FLOOD,
		SHAPE_BAD_RECORD,
		SHAPE_TRAILING,
		SHAPE_TRUNCATED,
		SHAPE_DANGLING,
		SHAPE_WILD_LENGTH,
		SHAPE_PLAIN
	} table_shape_t;

	// one result beat, unpacked
	typedef struct {
		logic        kind;
		logic [3:0]  cpu_slot;
		logic [7:0]  apic_ident;
		logic        cpu_on;
		logic        sum_ok;
		logic [31:0] local_apic_base;
		logic [31:0] io_apic_base;
		logic [7:0]  io_apic_ident;
		logic [31:0] irq_base;
		logic [4:0]  cpus_seen;
		logic        walk_halted;
	} madt_report_t;

	// Mirror of the table walk plus the queue of reports it predicts.
	class madt_walk_board;
		int unsigned  cpu_cap;
		bit [31:0]    offset;
		bit [31:0]    decl_len;
		bit [7:0]     csum;
		bit [31:0]    rec_start;
		bit [7:0]     rec_type;
		bit [7:0]     rec_len;
		bit [63:0]    rec_body;
		bit [7:0]     rec_ident;
		bit [31:0]    lapic_base;
		bit [31:0]    ioapic_base;
		bit [7:0]     ioapic_ident;
		bit [31:0]    irq_start;
		int unsigned  cpu_count;
		bit           halted;
		bit           cpu_due;
		madt_report_t cpu_report;
		madt_report_t pending_reports[$];
		int unsigned  failures;
		int unsigned  cpu_reports;
		int unsigned  table_ends;
		int unsigned  halted_walks;

		function new(int unsigned limit);
			cpu_cap = limit;
			failures = 0;
			cpu_reports = 0;
			table_ends = 0;
			halted_walks = 0;
			clear_walk();
		endfunction

		function void clear_walk();
			offset = '0;
			decl_len = '0;
			csum = '0;
			rec_start = madt_pkg::WALK_START;
			rec_type = '0;
			rec_len = '0;
			rec_body = '0;
			rec_ident = '0;
			lapic_base = '0;
			ioapic_base = '0;
			ioapic_ident = '0;
			irq_start = '0;
			cpu_count = 0;
			halted = 1'b0;
		endfunction

		// end of a record: count a CPU or latch the first live I/O APIC
		function void close_record();
			if (rec_type == madt_pkg::REC_LAPIC) begin
				if (cpu_count < cpu_cap) begin
					cpu_due = 1'b1;
					cpu_report = '{default: '0};
					cpu_report.kind = madt_pkg::KIND_CPU;
					cpu_report.cpu_slot = cpu_count[3:0];
					cpu_report.apic_ident = rec_ident;
					cpu_report.cpu_on = rec_body[0];
					cpu_count++;
				end
			end else if (rec_type == madt_pkg::REC_IOAPIC) begin
				if (ioapic_base == 0) begin
					ioapic_base = rec_body[31:0];
					ioapic_ident = rec_ident;
					irq_start = rec_body[63:32];
				end
			end
			rec_start += rec_len;
		endfunction

		// one accepted input beat
		function void absorb_byte(bit [7:0] b, bit last_beat);
			longint unsigned off;
			longint unsigned dl;
			longint unsigned rs;
			longint unsigned pos;
			bit              fits;
			madt_report_t    summary;

			cpu_due = 1'b0;
			off = offset;
			dl = decl_len;
			// the first eight bytes always count, the rest only inside the declared length
			if (off < 8 || off < dl)
				csum += b;
			if (off >= 4 && off <= 7)
				decl_len[(off - 4) * 8 +: 8] = b;
			if (off >= 36 && off <= 39)
				lapic_base[(off - 36) * 8 +: 8] = b;

			if (!halted && off >= madt_pkg::WALK_START) begin
				rs = rec_start;
				fits = (rs + 2 <= dl);
				if (fits && off == rs) begin
					rec_type = b;
					rec_body = '0;
					rec_ident = '0;
				end else if (fits && off == rs + 1) begin
					rec_len = b;
					if (b < 2 || rs + b > dl)
						halted = 1'b1;
					else if (b == 2)
						close_record();
				end else if (fits && off > rs + 1 && off - rs < rec_len) begin
					pos = off - rs;
					if (pos == 2) begin
						if (rec_type == madt_pkg::REC_IOAPIC)
							rec_ident = b;
					end else if (pos == 3) begin
						if (rec_type == madt_pkg::REC_LAPIC)
							rec_ident = b;
					end else if (pos >= 4 && pos <= 11) begin
						rec_body[(pos - 4) * 8 +: 8] = b;
					end
					if (pos + 1 == rec_len)
						close_record();
				end
			end

			if (offset != 32'hFFFF_FFFF)
				offset++;

			// a last beat reports the summary only, even if it closed a CPU record
			if (last_beat) begin
				summary.kind = madt_pkg::KIND_SUM;
				summary.cpu_slot = '0;
				summary.apic_ident = '0;
				summary.cpu_on = 1'b0;
				summary.sum_ok = (csum == 0);
				summary.local_apic_base = lapic_base;
				summary.io_apic_base = ioapic_base;
				summary.io_apic_ident = ioapic_ident;
				summary.irq_base = irq_start;
				summary.cpus_seen = cpu_count[4:0];
				summary.walk_halted = halted;
				pending_reports.push_back(summary);
				table_ends++;
				if (halted)
					halted_walks++;
				clear_walk();
			end else if (cpu_due) begin
				pending_reports.push_back(cpu_report);
				cpu_reports++;
			end
		endfunction

		function string describe(madt_report_t r);
			return $sformatf({"kind=%0d slot=%0d apic=%h on=%0d ok=%0d lapic=%h ",
				"ioapic=%h ioid=%h gsi=%h cpus=%0d halt=%0d"},
				r.kind, r.cpu_slot, r.apic_ident, r.cpu_on, r.sum_ok, r.local_apic_base,
				r.io_apic_base, r.io_apic_ident, r.irq_base, r.cpus_seen, r.walk_halted);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%0t: mismatch: %s", $realtime, msg);
		endfunction

		// one accepted output beat, compared field by field with the oldest prediction
		function void check_report(logic [127:0] data, logic user);
			madt_report_t want;
			madt_report_t got;
			bit           bad;

			got.kind = user;
			got.cpu_slot = data[3:0];
			got.apic_ident = data[11:4];
			got.cpu_on = data[12];
			got.sum_ok = data[13];
			got.local_apic_base = data[45:14];
			got.io_apic_base = data[77:46];
			got.io_apic_ident = data[85:78];
			got.irq_base = data[117:86];
			got.cpus_seen = data[122:118];
			got.walk_halted = data[123];
			if (pending_reports.size() == 0) begin
				note_failure({"beat with nothing expected: ", describe(got)});
				return;
			end
			want = pending_reports.pop_front();
			bad = (data[127:124] !== 4'd0);
			if (got.kind !== want.kind) bad = 1'b1;
			if (got.cpu_slot !== want.cpu_slot) bad = 1'b1;
			if (got.apic_ident !== want.apic_ident) bad = 1'b1;
			if (got.cpu_on !== want.cpu_on) bad = 1'b1;
			if (got.sum_ok !== want.sum_ok) bad = 1'b1;
			if (got.local_apic_base !== want.local_apic_base) bad = 1'b1;
			if (got.io_apic_base !== want.io_apic_base) bad = 1'b1;
			if (got.io_apic_ident !== want.io_apic_ident) bad = 1'b1;
			if (got.irq_base !== want.irq_base) bad = 1'b1;
			if (got.cpus_seen !== want.cpus_seen) bad = 1'b1;
			if (got.walk_halted !== want.walk_halted) bad = 1'b1;
			if (bad)
				note_failure({"expected ", describe(want), " got ", describe(got),
					$sformatf(" pad=%h", data[127:124])});
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         m_tuser;

	madt_walk_board board;
	bit [7:0]       table_bytes[$];
	bit             quiet = 1'b0;          // no idling on either side while set
	bit             hold_request = 1'b0;   // asks the sink for one long hold-off
	bit             hold_done = 1'b0;
	int unsigned    hold_left = 0;
	int unsigned    bytes_sent = 0;
	int unsigned    tables_sent = 0;
	int unsigned    cycle_count = 0;

	madt_table_stream_parser_top #(
		.CPU_LIMIT(CPU_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Run limit: a correct run needs a small fraction of this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still expected",
				cycle_count, board.pending_reports.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sink: checks every taken beat, stalls at random, and once holds off
	// for a long stretch so the output register fills and s_tready drops.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_report(m_tdata, m_tuser);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// type, length, then random body; blank_addr zeroes an I/O APIC address
	function automatic void append_record(bit [7:0] code, int unsigned len, bit blank_addr);
		int unsigned k;

		table_bytes.push_back(code);
		table_bytes.push_back(len[7:0]);
		for (k = 2; k < len; k++)
			table_bytes.push_back((blank_addr && k >= 4 && k <= 7) ? 8'h00 : 8'($urandom));
	endfunction

	// mostly CPUs and I/O APICs, some short or odd-sized, plus records to skip
	function automatic void append_mixed_record();
		int unsigned pick;
		int unsigned len;

		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 8;
			append_record(madt_pkg::REC_LAPIC, len, 1'b0);
		end else if (pick < 65) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 14) : 12;
			append_record(madt_pkg::REC_IOAPIC, len, $urandom_range(0, 3) == 0);
		end else if (pick < 80) begin
			append_record(REC_OVERRIDE, 10, 1'b0);
		end else if (pick < 90) begin
			append_record(REC_NMI, 6, 1'b0);
		end else begin
			append_record(8'($urandom_range(2, 255)), $urandom_range(2, 16), 1'b0);
		end
	endfunction

	// Builds one table into table_bytes: 44-byte header, records, then the
	// shape-specific damage, declared length and (usually) a fixed checksum; noise is random bytes only.
	function automatic void compose_table(table_shape_t shape);
		int unsigned n;
		int unsigned k;
		int unsigned cut;
		bit [31:0]   decl;
		bit [31:0]   addr;
		bit [7:0]    sum;

		table_bytes.delete();
		if (shape == SHAPE_NOISE) begin
			n = $urandom_range(1, 60);
			repeat (n) table_bytes.push_back(8'($urandom));
			return;
		end

		table_bytes.push_back("A");
		table_bytes.push_back("P");
		table_bytes.push_back("I");
		table_bytes.push_back("C");
		repeat (4) table_bytes.push_back(8'h00);
		for (k = 8; k < 36; k++)
			table_bytes.push_back(8'($urandom));
		case ($urandom_range(0, 3))
			0: addr = 32'hFEE0_0000;
			1: addr = 32'h0000_0000;
			2: addr = 32'hFFFF_FFFF;
			default: addr = $urandom;
		endcase
		for (k = 0; k < 4; k++)
			table_bytes.push_back(addr[k * 8 +: 8]);
		repeat (4) table_bytes.push_back(8'($urandom));

		if (shape == SHAPE_CPU_FLOOD) begin
			n = $urandom_range(CPU_CAP + 1, CPU_CAP + 4);
			repeat (n) append_record(madt_pkg::REC_LAPIC, 8, 1'b0);
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) append_mixed_record();
		end

		if (shape == SHAPE_BAD_RECORD) begin
			table_bytes.push_back(8'($urandom));
			case ($urandom_range(0, 2))
				0: table_bytes.push_back(8'd0);
				1: table_bytes.push_back(8'd1);
				default: begin
					// length of 12 or more, which can run past the end of the table
					table_bytes.push_back(8'($urandom_range(12, 255)));
					n = $urandom_range(0, 8);
					repeat (n) table_bytes.push_back(8'($urandom));
				end
			endcase
			// records after the bad one must be ignored
			n = $urandom_range(0, 2);
			repeat (n) append_mixed_record();
		end

		// last byte closes a CPU record: counted, but only the summary comes out
		if (shape == SHAPE_PLAIN && $urandom_range(0, 1) == 1)
			append_record(madt_pkg::REC_LAPIC, 8, 1'b0);
		// a lone byte too short to start a record
		if (shape == SHAPE_DANGLING)
			table_bytes.push_back(8'($urandom));

		decl = table_bytes.size();
		if (shape == SHAPE_WILD_LENGTH) begin
			case ($urandom_range(0, 3))
				0: decl = $urandom;
				1: decl = 32'hFFFF_FFFF;
				2: decl = decl + $urandom_range(1, 40);
				default: decl = $urandom_range(0, 43);
			endcase
		end
		if (shape == SHAPE_TRAILING) begin
			n = $urandom_range(1, 6);
			repeat (n) table_bytes.push_back(8'($urandom));
		end
		for (k = 0; k < 4; k++)
			table_bytes[4 + k] = decl[k * 8 +: 8];
		if (shape == SHAPE_TRUNCATED) begin
			cut = $urandom_range(1, 12);
			repeat (cut) void'(table_bytes.pop_back());
		end

		if ($urandom_range(0, 99) < 85) begin
			table_bytes[9] = 8'h00;
			sum = 8'h00;
			for (k = 0; k < table_bytes.size(); k++)
				if (k < 8 || k < decl)
					sum += table_bytes[k];
			table_bytes[9] = -sum;
		end
	endfunction

	// Streams table_bytes, tlast on the final byte; valid stays up between
	// beats unless a random idle gap is taken.
	task automatic stream_table();
		int unsigned i;
		int unsigned gap;
		bit          last_beat;

		for (i = 0; i < table_bytes.size(); i++) begin
			last_beat = (i == table_bytes.size() - 1);
			if (!quiet && $urandom_range(0, 99) < 8) begin
				s_tvalid <= 1'b0;
				gap = $urandom_range(1, 4);
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= table_bytes[i];
			s_tlast <= last_beat;
			do
				@(posedge clk);
			while (!s_tready);
			board.absorb_byte(table_bytes[i], last_beat);
			bytes_sent++;
		end
		tables_sent++;
	endtask

	initial begin
		int unsigned  idx;
		table_shape_t shape;

		board = new(CPU_CAP);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: one-byte tables at both extremes, then a header cut short
		// with an all-ones declared length.
		table_bytes = '{8'h00};
		stream_table();
		table_bytes = '{8'hFF};
		stream_table();
		table_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h01, 8'h80};
		stream_table();

		// Random tables, rotating through the shapes so each one recurs.
		while (bytes_sent < TARGET_BYTES) begin
			idx = tables_sent % 10;
			shape = (idx >= SHAPE_PLAIN) ? SHAPE_PLAIN : table_shape_t'(idx);
			quiet = (tables_sent >= 6 && tables_sent < 10);
			if (tables_sent == 12)
				hold_request = 1'b1;
			compose_table(shape);
			stream_table();
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (board.pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d tables in %0d byte beats: %0d CPU reports, %0d summaries",
			tables_sent, bytes_sent, board.cpu_reports, board.table_ends);
		$display("walks halted by bad records: %0d; sink hold-off of %0d cycles; %0d mismatches",
			board.halted_walks, HOLD_CYCLES, board.failures);
		if (board.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
